/* rtl/core/pls_pkg.sv */
// Shared types and constants of the periodic Laplacian stencil block.
`timescale 1ns / 1ps
`default_nettype none

package pls_pkg;

   // Fixed field widths
   localparam int ROW_W  = 6;
   localparam int COL_W  = 6;
   localparam int SIZE_W = 7;
   localparam int INV_W  = 16;
   localparam int LAP_W  = 32;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   // Operation codes carried in req_tuser
   localparam logic OP_WRITE   = 1'b0;
   localparam logic OP_COMPUTE = 1'b1;

   // Status codes carried in rsp_tuser
   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_RANGE = 1'b1;

   // Register indexes of the CSR port
   localparam logic [CSR_INDEX_W-1:0] CSR_ROWS_IN_USE    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COLS_IN_USE    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_INV_DX_SQUARED = 2'd2;

   // Register reset values
   localparam logic [SIZE_W-1:0] ROWS_RESET = 7'd64;
   localparam logic [SIZE_W-1:0] COLS_RESET = 7'd64;
   localparam logic [INV_W-1:0]  INV_RESET  = 16'd256;

   // Datapath steering from the sequencer
   typedef struct packed {
      logic clear;      // start a new sum
      logic accumulate; // read data is valid this cycle
      logic centre;     // read data is the centre sample, weight -4
      logic multiply;   // scale the finished sum
   } dp_ctrl_type;

endpackage

`default_nettype wire

/* rtl/core/periodic_laplacian_stencil.sv */
// Top level of the periodic five-point Laplacian stencil block.
// Holds a mesh of signed Q8.8 samples in one single-port memory (MAX_ROWS by MAX_COLS,
// row and column indexes padded to powers of two). A write transaction (operation 0)
// stores one sample; a write outside the configured size is dropped silently and
// gives no result. A compute transaction (operation 1) gives one result: it reads
// the centre and four wrapped neighbours through the one memory port, adds the last
// sample, multiplies by inv_dx_squared and rounds into the output register. The next
// item is taken in the cycle after the result is registered, so no new request is
// taken while a compute is in flight. A compute outside the configured size gives
// status 1 and a zero Laplacian. Mesh contents are undefined after reset until
// written; there is no clearing pass. Size registers read as zero are taken as one,
// above the maximum as the maximum. Registers may be changed only while no item is
// in flight.
`timescale 1ns / 1ps
`default_nettype none

module periodic_laplacian_stencil #(
   parameter int MAX_ROWS    = 64,
   parameter int MAX_COLS    = 64,
   parameter int SAMPLE_BITS = 16,
   localparam int REQ_W = ((pls_pkg::ROW_W + pls_pkg::COL_W + SAMPLE_BITS + 7) / 8) * 8
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // Request stream
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   input  wire logic [REQ_W-1:0]                   req_tdata,  // row, col, sample, zero pad
   input  wire logic                               req_tuser,  // operation
   // Response stream
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   output logic [pls_pkg::LAP_W-1:0]               rsp_tdata,  // laplacian
   output logic                                    rsp_tuser,  // status
   // Register write port
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [pls_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [pls_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int RW     = $clog2(MAX_ROWS);
   localparam int CW     = $clog2(MAX_COLS);
   localparam int ADDR_W = RW + CW;
   localparam int SW     = pls_pkg::SIZE_W;

   // Read order of the stencil taps
   localparam logic [2:0] TAP_CENTRE = 3'd0;
   localparam logic [2:0] TAP_UP     = 3'd1;
   localparam logic [2:0] TAP_DOWN   = 3'd2;
   localparam logic [2:0] TAP_LEFT   = 3'd3;
   localparam logic [2:0] TAP_RIGHT  = 3'd4;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_WAIT,
      S_MUL,
      S_DONE
   } state_type;

   // Request fields
   logic [pls_pkg::ROW_W-1:0] req_row;
   logic [pls_pkg::COL_W-1:0] req_col;
   logic [SAMPLE_BITS-1:0]    req_sample;

   assign req_row    = req_tdata[pls_pkg::ROW_W-1:0];
   assign req_col    = req_tdata[pls_pkg::ROW_W +: pls_pkg::COL_W];
   assign req_sample = req_tdata[pls_pkg::ROW_W + pls_pkg::COL_W +: SAMPLE_BITS];

   // Configuration registers
   logic [SW-1:0]             rows_in_use_ff;
   logic [SW-1:0]             cols_in_use_ff;
   logic [pls_pkg::INV_W-1:0] inv_dx_squared_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_in_use_ff    <= pls_pkg::ROWS_RESET;
         cols_in_use_ff    <= pls_pkg::COLS_RESET;
         inv_dx_squared_ff <= pls_pkg::INV_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            pls_pkg::CSR_ROWS_IN_USE:    rows_in_use_ff    <= csr_wdata[SW-1:0];
            pls_pkg::CSR_COLS_IN_USE:    cols_in_use_ff    <= csr_wdata[SW-1:0];
            pls_pkg::CSR_INV_DX_SQUARED: inv_dx_squared_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;

   // Effective mesh size: zero means one, capped at the maximum
   logic [SW-1:0] n_rows;
   logic [SW-1:0] n_cols;

   always_comb begin
      n_rows = rows_in_use_ff;
      if (rows_in_use_ff == '0) begin
         n_rows = SW'(1);
      end else if (32'(rows_in_use_ff) > 32'(MAX_ROWS)) begin
         n_rows = SW'(MAX_ROWS);
      end
      n_cols = cols_in_use_ff;
      if (cols_in_use_ff == '0) begin
         n_cols = SW'(1);
      end else if (32'(cols_in_use_ff) > 32'(MAX_COLS)) begin
         n_cols = SW'(MAX_COLS);
      end
   end

   // Range check and wrapped neighbour indexes of the requested point
   logic          in_mesh;
   logic [SW-1:0] row_ext, col_ext;
   logic [SW-1:0] row_dn, row_up, col_lf, col_rt;

   always_comb begin
      row_ext = SW'(req_row);
      col_ext = SW'(req_col);
      in_mesh = (row_ext < n_rows) && (col_ext < n_cols);
      row_up  = (row_ext == '0) ? n_rows - SW'(1) : row_ext - SW'(1);
      row_dn  = (row_ext + SW'(1) == n_rows) ? '0 : row_ext + SW'(1);
      col_lf  = (col_ext == '0) ? n_cols - SW'(1) : col_ext - SW'(1);
      col_rt  = (col_ext + SW'(1) == n_cols) ? '0 : col_ext + SW'(1);
   end

   // Sequencer
   state_type                 state_ff,    state_in;
   logic [2:0]                tap_ff,      tap_in;
   logic                      rd_valid_ff, rd_valid_in;
   logic                      rd_centre_ff, rd_centre_in;
   logic                      err_ff,      err_in;
   logic                      rsp_tvalid_ff, rsp_tvalid_in;
   logic [pls_pkg::LAP_W-1:0] rsp_tdata_ff,  rsp_tdata_in;
   logic                      rsp_tuser_ff,  rsp_tuser_in;

   // Point indexes held for the reads
   logic [RW-1:0] row_ff, row_up_ff, row_dn_ff;
   logic [CW-1:0] col_ff, col_lf_ff, col_rt_ff;

   logic                      req_accept;
   logic                      load_rsp;
   logic signed [pls_pkg::LAP_W-1:0] laplacian;

   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign load_rsp   = (state_ff == S_DONE) && (!rsp_tvalid_ff || rsp_tready);

   always_comb begin
      state_in      = state_ff;
      tap_in        = tap_ff;
      err_in        = err_ff;
      rd_valid_in   = (state_ff == S_READ);
      rd_centre_in  = (state_ff == S_READ) && (tap_ff == TAP_CENTRE);
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept && (req_tuser == pls_pkg::OP_COMPUTE)) begin
               tap_in   = TAP_CENTRE;
               err_in   = !in_mesh;
               state_in = in_mesh ? S_READ : S_DONE;
            end
         end
         S_READ: begin
            if (tap_ff == TAP_RIGHT) begin
               state_in = S_WAIT;
            end else begin
               tap_in = tap_ff + 3'd1;
            end
         end
         S_WAIT: state_in = S_MUL;
         S_MUL:  state_in = S_DONE;
         S_DONE: begin
            if (load_rsp) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = err_ff ? '0 : laplacian;
               rsp_tuser_in  = err_ff ? pls_pkg::STATUS_RANGE : pls_pkg::STATUS_OK;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         tap_ff        <= TAP_CENTRE;
         rd_valid_ff   <= 1'b0;
         rd_centre_ff  <= 1'b0;
         err_ff        <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         tap_ff        <= tap_in;
         rd_valid_ff   <= rd_valid_in;
         rd_centre_ff  <= rd_centre_in;
         err_ff        <= err_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tuser_ff <= rsp_tuser_in;
   end

   // Capture the point and its neighbours on every accepted request
   always_ff @(posedge clock) begin
      if (req_accept) begin
         row_ff    <= RW'(row_ext);
         row_up_ff <= RW'(row_up);
         row_dn_ff <= RW'(row_dn);
         col_ff    <= CW'(col_ext);
         col_lf_ff <= CW'(col_lf);
         col_rt_ff <= CW'(col_rt);
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   // Memory port: writes straight from the request, reads one tap a cycle
   logic                   mem_en;
   logic                   mem_we;
   logic [ADDR_W-1:0]      mem_addr;
   logic [SAMPLE_BITS-1:0] mem_rdata;

   always_comb begin
      mem_en   = 1'b0;
      mem_we   = 1'b0;
      mem_addr = {RW'(row_ext), CW'(col_ext)};
      if (req_accept && (req_tuser == pls_pkg::OP_WRITE) && in_mesh) begin
         mem_en = 1'b1;
         mem_we = 1'b1;
      end else if (state_ff == S_READ) begin
         mem_en = 1'b1;
         unique case (tap_ff)
            TAP_CENTRE: mem_addr = {row_ff,    col_ff};
            TAP_UP:     mem_addr = {row_up_ff, col_ff};
            TAP_DOWN:   mem_addr = {row_dn_ff, col_ff};
            TAP_LEFT:   mem_addr = {row_ff,    col_lf_ff};
            TAP_RIGHT:  mem_addr = {row_ff,    col_rt_ff};
            default:    mem_addr = {row_ff,    col_ff};
         endcase
      end
   end

   pls_mesh_mem #(
      .ADDR_W (ADDR_W),
      .DATA_W (SAMPLE_BITS)
   ) u_mesh_mem (
      .clock     (clock),
      .mem_en    (mem_en),
      .mem_we    (mem_we),
      .mem_addr  (mem_addr),
      .mem_wdata (req_sample),
      .mem_rdata (mem_rdata)
   );

   // Datapath steering
   pls_pkg::dp_ctrl_type dp_ctrl;

   always_comb begin
      dp_ctrl.clear      = req_accept;
      dp_ctrl.accumulate = rd_valid_ff;
      dp_ctrl.centre     = rd_centre_ff;
      dp_ctrl.multiply   = (state_ff == S_MUL);
   end

   pls_laplace_dp #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_laplace_dp (
      .clock          (clock),
      .dp_ctrl        (dp_ctrl),
      .rd_sample      (mem_rdata),
      .inv_dx_squared (inv_dx_squared_ff),
      .laplacian      (laplacian)
   );

endmodule

`default_nettype wire

/* rtl/core/pls_mesh_mem.sv */
// Single-port synchronous mesh memory with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module pls_mesh_mem #(
   parameter int ADDR_W = 12,
   parameter int DATA_W = 16
) (
   input  wire logic              clock,
   input  wire logic              mem_en,
   input  wire logic              mem_we,
   input  wire logic [ADDR_W-1:0] mem_addr,
   input  wire logic [DATA_W-1:0] mem_wdata,
   output logic      [DATA_W-1:0] mem_rdata
);

   logic [DATA_W-1:0] store_ff [2**ADDR_W];
   logic [DATA_W-1:0] rdata_ff;

   // One access a cycle: write, or read into the registered read data
   always_ff @(posedge clock) begin
      if (mem_en) begin
         if (mem_we) begin
            store_ff[mem_addr] <= mem_wdata;
         end else begin
            rdata_ff <= store_ff[mem_addr];
         end
      end
   end

   assign mem_rdata = rdata_ff;

endmodule

`default_nettype wire

/* rtl/core/pls_laplace_dp.sv */
// Stencil datapath: accumulates the five samples, scales and rounds the sum.
`timescale 1ns / 1ps
`default_nettype none

module pls_laplace_dp #(
   parameter int SAMPLE_BITS = 16
) (
   input  wire logic                          clock,
   input  wire pls_pkg::dp_ctrl_type          dp_ctrl,
   input  wire logic [SAMPLE_BITS-1:0]        rd_sample,
   input  wire logic [pls_pkg::INV_W-1:0]     inv_dx_squared,
   output logic signed [pls_pkg::LAP_W-1:0]   laplacian
);

   // Sum of four neighbours less four centres needs three more bits
   localparam int ACC_W  = SAMPLE_BITS + 3;
   localparam int PROD_W = ACC_W + pls_pkg::INV_W + 1;
   localparam logic signed [PROD_W-1:0] ROUND_BIAS = PROD_W'(128);

   logic signed [ACC_W-1:0]  acc_ff,  acc_in;
   logic signed [ACC_W-1:0]  term;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [PROD_W-1:0] rounded;

   // Weight the incoming sample: centre counts minus four times
   always_comb begin
      term = ACC_W'($signed(rd_sample));
      if (dp_ctrl.centre) begin
         term = -(term <<< 2);
      end
   end

   // Running sum
   always_comb begin
      acc_in = acc_ff;
      if (dp_ctrl.clear) begin
         acc_in = '0;
      end else if (dp_ctrl.accumulate) begin
         acc_in = acc_ff + term;
      end
   end

   // Scale by 1/dx^2 (unsigned Q8.8), product is Q20.16
   always_comb begin
      prod_in = prod_ff;
      if (dp_ctrl.multiply) begin
         prod_in = PROD_W'(acc_ff) * PROD_W'($signed({1'b0, inv_dx_squared}));
      end
   end

   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      prod_ff <= prod_in;
   end

   // Back to Q24.8 on the 32-bit output, rounded half up (floor after adding half an LSB)
   assign rounded   = (prod_ff + ROUND_BIAS) >>> 8;
   assign laplacian = pls_pkg::LAP_W'(rounded);

endmodule

`default_nettype wire

/* rtl/core/pls_checker.sv */
// Port-level checks of the stencil block and their binding to the top level.
`timescale 1ns / 1ps
`default_nettype none

module pls_checker (
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       req_tvalid,
   input wire logic                       req_tready,
   input wire logic                       req_tuser,
   input wire logic                       rsp_tvalid,
   input wire logic                       rsp_tready,
   input wire logic [pls_pkg::LAP_W-1:0]  rsp_tdata,
   input wire logic                       rsp_tuser
);

   // A stalled response holds its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // An out-of-range result carries a zero Laplacian
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == pls_pkg::STATUS_RANGE) |-> rsp_tdata == '0)
      else $error("range error with non-zero data");

   // Nothing is offered straight after reset
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // A write transaction never raises a response
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == pls_pkg::OP_WRITE) && !rsp_tvalid
      |=> !rsp_tvalid)
      else $error("response raised by a write");

endmodule

bind periodic_laplacian_stencil pls_checker u_pls_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

/* tb/periodic_laplacian_stencil_checker.sv */
// Checker for the periodic Laplacian stencil: mirrors the mesh, predicts and compares results.
`timescale 1ns / 1ps
`default_nettype none

module periodic_laplacian_stencil_checker #(
   parameter int MESH_ROWS = 64,
   parameter int MESH_COLS = 64,
   parameter int REQ_W     = 32
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   input  wire logic                               req_tready,
   input  wire logic [REQ_W-1:0]                   req_tdata,  // row, col, sample, zero pad
   input  wire logic                               req_tuser,  // operation
   input  wire logic                               rsp_tvalid,
   input  wire logic                               rsp_tready,
   input  wire logic [pls_pkg::LAP_W-1:0]          rsp_tdata,  // laplacian
   input  wire logic                               rsp_tuser,  // status
   input  wire logic                               csr_valid,
   input  wire logic                               csr_ready,
   input  wire logic [pls_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [pls_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output int                                      results_owed,
   output int                                      mismatch_count,
   output int                                      results_checked,
   output int                                      range_results
);

   typedef struct packed {
      logic [pls_pkg::LAP_W-1:0] laplacian;
      logic                      status;
   } stencil_result_type;

   // Shadow of the mesh and of the registers
   logic signed [15:0]           mesh_copy [0:MESH_ROWS*MESH_COLS-1];
   logic [pls_pkg::SIZE_W-1:0]   rows_cfg;
   logic [pls_pkg::SIZE_W-1:0]   cols_cfg;
   logic [pls_pkg::INV_W-1:0]    inv_cfg;
   stencil_result_type           results_due [$];
   int                           mismatches = 0;
   int                           checked = 0;
   int                           ranged = 0;

   // Size register as the block uses it: zero reads as one, large values clip
   function automatic int span(input logic [pls_pkg::SIZE_W-1:0] v, input int limit);
      if (v == 0) return 1;
      if (v > limit) return limit;
      return v;
   endfunction

   function automatic longint mesh_value(input int r, input int c);
      return longint'(mesh_copy[r*MESH_COLS + c]);
   endfunction

   // Five-point stencil with periodic wrap, scaled and rounded half up to Q24.8
   function automatic stencil_result_type laplacian_at(input int r, input int c);
      int                 nr;
      int                 nc;
      int                 up;
      int                 down;
      int                 left;
      int                 right;
      longint             total;
      stencil_result_type res;
      nr = span(rows_cfg, MESH_ROWS);
      nc = span(cols_cfg, MESH_COLS);
      if (r >= nr || c >= nc) begin
         res.laplacian = '0;
         res.status    = pls_pkg::STATUS_RANGE;
         return res;
      end
      up    = (r == 0) ? nr - 1 : r - 1;
      down  = (r + 1 == nr) ? 0 : r + 1;
      left  = (c == 0) ? nc - 1 : c - 1;
      right = (c + 1 == nc) ? 0 : c + 1;
      total = mesh_value(up, c) + mesh_value(down, c) + mesh_value(r, left)
            + mesh_value(r, right) - 4 * mesh_value(r, c);
      total = total * longint'(inv_cfg);
      total = (total + 128) >>> 8;
      res.laplacian = total[31:0];
      res.status    = pls_pkg::STATUS_OK;
      return res;
   endfunction

   always @(posedge clock) begin : watch
      stencil_result_type want;
      if (reset) begin
         rows_cfg = pls_pkg::ROWS_RESET;
         cols_cfg = pls_pkg::COLS_RESET;
         inv_cfg  = pls_pkg::INV_RESET;
         results_due.delete();
      end else begin
         // register write transaction; unmapped index is ignored
         if (csr_valid && csr_ready) begin
            case (csr_index)
               pls_pkg::CSR_ROWS_IN_USE:    rows_cfg = csr_wdata[pls_pkg::SIZE_W-1:0];
               pls_pkg::CSR_COLS_IN_USE:    cols_cfg = csr_wdata[pls_pkg::SIZE_W-1:0];
               pls_pkg::CSR_INV_DX_SQUARED: inv_cfg  = csr_wdata;
               default: ;
            endcase
         end

         // result transaction against the oldest expectation
         if (rsp_tvalid && rsp_tready) begin
            if (results_due.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected result: expected none, actual laplacian %0d status %0d",
                        $time, $signed(rsp_tdata), rsp_tuser);
            end else begin
               want = results_due.pop_front();
               checked++;
               if (rsp_tuser == pls_pkg::STATUS_RANGE) ranged++;
               if (rsp_tdata !== want.laplacian) begin
                  mismatches++;
                  $display("%0t: laplacian mismatch: expected %0d, actual %0d",
                           $time, $signed(want.laplacian), $signed(rsp_tdata));
               end
               if (rsp_tuser !== want.status) begin
                  mismatches++;
                  $display("%0t: status mismatch: expected %0d, actual %0d",
                           $time, want.status, rsp_tuser);
               end
            end
         end

         // request transaction: store a sample or queue the expected Laplacian
         if (req_tvalid && req_tready) begin
            if (req_tuser == pls_pkg::OP_COMPUTE)
               results_due = {results_due, laplacian_at(req_tdata[5:0], req_tdata[11:6])};
            else if (req_tdata[5:0] < span(rows_cfg, MESH_ROWS)
                     && req_tdata[11:6] < span(cols_cfg, MESH_COLS))
               mesh_copy[req_tdata[5:0]*MESH_COLS + req_tdata[11:6]] = req_tdata[27:12];
         end
      end
      results_owed    <= results_due.size();
      mismatch_count  <= mismatches;
      results_checked <= checked;
      range_results   <= ranged;
   end

endmodule

`default_nettype wire

/* tb/periodic_laplacian_stencil_tb.sv */
// Testbench top for the periodic Laplacian stencil: stimulus, idling and the verdict.
`timescale 1ns / 1ps
`default_nettype none

module periodic_laplacian_stencil_tb;

   localparam int MESH_ROWS     = 64;
   localparam int MESH_COLS     = 64;
   localparam int REQ_W         = ((pls_pkg::ROW_W + pls_pkg::COL_W + 16 + 7) / 8) * 8;
   localparam int ITEM_TARGET   = 1000;
   localparam int QUIET_ITEMS   = 100;
   localparam int SETTLE_CYCLES = 16;
   localparam int CYCLE_LIMIT   = 800000;
   localparam logic [pls_pkg::CSR_INDEX_W-1:0] CSR_UNMAPPED = 2'd3;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_tvalid = 1'b0;
   logic                               req_tready;
   logic [REQ_W-1:0]                   req_tdata = '0;  // row, col, sample, zero pad
   logic                               req_tuser = pls_pkg::OP_WRITE;  // operation
   logic                               rsp_tvalid;
   logic                               rsp_tready = 1'b1;
   logic [pls_pkg::LAP_W-1:0]          rsp_tdata;  // laplacian
   logic                               rsp_tuser;  // status
   logic                               csr_valid = 1'b0;
   logic                               csr_ready;
   logic [pls_pkg::CSR_INDEX_W-1:0]    csr_index = pls_pkg::CSR_ROWS_IN_USE;
   logic [pls_pkg::CSR_DATA_W-1:0]     csr_wdata = '0;

   int  results_owed;
   int  mismatch_count;
   int  results_checked;
   int  range_results;

   bit  quiet = 1'b0;
   int  cycle_count = 0;
   int  writes_sent = 0;
   int  writes_kept = 0;
   int  computes_sent = 0;
   int  settings_used = 0;
   int  rows_eff = MESH_ROWS;
   int  cols_eff = MESH_COLS;
   bit  written [0:MESH_ROWS*MESH_COLS-1];
   int  sink_hold = 0;
   bit  sink_stall = 1'b0;

   always #1 clock = ~clock;

   periodic_laplacian_stencil i_dut (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser,
      .csr_valid, .csr_ready, .csr_index, .csr_wdata
   );

   periodic_laplacian_stencil_checker #(
      .MESH_ROWS(MESH_ROWS), .MESH_COLS(MESH_COLS), .REQ_W(REQ_W)
   ) i_checker (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser,
      .csr_valid, .csr_ready, .csr_index, .csr_wdata,
      .results_owed, .mismatch_count, .results_checked, .range_results
   );

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("periodic_laplacian_stencil_tb failed");
         $finish;
      end
   end

   // Result side: alternating ready and stall bursts, always ready when quiet
   always @(posedge clock) begin
      if (reset || quiet) begin
         sink_hold = 0;
         rsp_tready <= 1'b1;
      end else begin
         if (sink_hold == 0) begin
            sink_stall = ($urandom_range(0, 3) == 0);
            sink_hold  = sink_stall ? $urandom_range(1, 14) : $urandom_range(1, 40);
         end
         sink_hold--;
         rsp_tready <= !sink_stall;
      end
   end

   function automatic int size_in_use(input logic [pls_pkg::SIZE_W-1:0] v, input int limit);
      if (v == 0) return 1;
      if (v > limit) return limit;
      return v;
   endfunction

   function automatic logic [15:0] pick_sample();
      case ($urandom_range(0, 7))
         0:       return 16'h7FFF;
         1:       return 16'h8000;
         default: return 16'($urandom);
      endcase
   endfunction

   // Favour the wrap points of a dimension
   function automatic int pick_index(input int n);
      case ($urandom_range(0, 3))
         0:       return 0;
         1:       return n - 1;
         default: return $urandom_range(0, n - 1);
      endcase
   endfunction

   function automatic logic [pls_pkg::SIZE_W-1:0] pick_size();
      case ($urandom_range(0, 9))
         0:       return 7'd0;
         1:       return 7'd1;
         2:       return 7'd64;
         3:       return 7'($urandom_range(65, 127));
         4, 5:    return 7'($urandom_range(1, 64));
         default: return 7'($urandom_range(2, 8));
      endcase
   endfunction

   // One request transaction, with an occasional idle burst in front
   task automatic send_item(input logic op, input int row, input int col,
                            input logic [15:0] sample);
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= REQ_W'({sample, 6'(col), 6'(row)});
      do @(posedge clock); while (!req_tready);
      if (op == pls_pkg::OP_COMPUTE) computes_sent++;
      else writes_sent++;
   endtask

   task automatic put_sample(input int row, input int col, input logic [15:0] sample);
      send_item(pls_pkg::OP_WRITE, row, col, sample);
      if (row < rows_eff && col < cols_eff) begin
         written[row*MESH_COLS + col] = 1'b1;
         writes_kept++;
      end
   endtask

   task automatic ensure_written(input int row, input int col);
      if (!written[row*MESH_COLS + col]) put_sample(row, col, pick_sample());
   endtask

   // Laplacian request at an in-range point; all five taps are stored first
   task automatic probe(input int row, input int col);
      int up;
      int down;
      int left;
      int right;
      up    = (row == 0) ? rows_eff - 1 : row - 1;
      down  = (row + 1 == rows_eff) ? 0 : row + 1;
      left  = (col == 0) ? cols_eff - 1 : col - 1;
      right = (col + 1 == cols_eff) ? 0 : col + 1;
      ensure_written(row, col);
      ensure_written(up, col);
      ensure_written(down, col);
      ensure_written(row, left);
      ensure_written(row, right);
      send_item(pls_pkg::OP_COMPUTE, row, col, 16'($urandom));
   endtask

   // Laplacian request outside the mesh in use; caller makes sure one exists
   task automatic probe_outside();
      int row;
      int col;
      row = $urandom_range(0, MESH_ROWS - 1);
      col = $urandom_range(0, MESH_COLS - 1);
      if (cols_eff == MESH_COLS || (rows_eff < MESH_ROWS && $urandom_range(0, 1) == 0))
         row = $urandom_range(rows_eff, MESH_ROWS - 1);
      else
         col = $urandom_range(cols_eff, MESH_COLS - 1);
      send_item(pls_pkg::OP_COMPUTE, row, col, 16'($urandom));
   endtask

   // Drain: all results back, then let any trailing write finish
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (results_owed != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [pls_pkg::CSR_INDEX_W-1:0] index,
                            input logic [pls_pkg::CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic apply_setting(input logic [15:0] rows_w, input logic [15:0] cols_w,
                                input logic [15:0] inv_w);
      wait_idle();
      if (settings_used == 0 || $urandom_range(0, 2) == 0)
         write_reg(CSR_UNMAPPED, 16'($urandom));
      write_reg(pls_pkg::CSR_ROWS_IN_USE, rows_w);
      write_reg(pls_pkg::CSR_COLS_IN_USE, cols_w);
      write_reg(pls_pkg::CSR_INV_DX_SQUARED, inv_w);
      csr_valid <= 1'b0;
      rows_eff = size_in_use(rows_w[pls_pkg::SIZE_W-1:0], MESH_ROWS);
      cols_eff = size_in_use(cols_w[pls_pkg::SIZE_W-1:0], MESH_COLS);
      settings_used++;
   endtask

   task automatic program_random();
      logic [15:0] inv_w;
      case ($urandom_range(0, 7))
         0:       inv_w = 16'd0;
         1:       inv_w = 16'hFFFF;
         2:       inv_w = 16'd256;
         3:       inv_w = 16'($urandom_range(1, 15));
         default: inv_w = 16'($urandom);
      endcase
      apply_setting({9'($urandom), pick_size()}, {9'($urandom), pick_size()}, inv_w);
   endtask

   // Mostly well-formed Laplacian requests, plus stray writes and out-of-range requests
   task automatic run_phase(input int count);
      int n;
      int pick;
      for (n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 10)
            put_sample($urandom_range(0, MESH_ROWS - 1), $urandom_range(0, MESH_COLS - 1),
                       pick_sample());
         else if (pick < 20)
            put_sample(pick_index(rows_eff), pick_index(cols_eff), pick_sample());
         else if (pick < 30 && (rows_eff < MESH_ROWS || cols_eff < MESH_COLS))
            probe_outside();
         else
            probe(pick_index(rows_eff), pick_index(cols_eff));
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset setting: centre at the maximum, neighbours at the minimum
      put_sample(0, 0, 16'h7FFF);
      put_sample(1, 0, 16'h8000);
      put_sample(MESH_ROWS - 1, 0, 16'h8000);
      put_sample(0, 1, 16'h8000);
      put_sample(0, MESH_COLS - 1, 16'h8000);
      probe(0, 0);
      put_sample(MESH_ROWS - 1, MESH_COLS - 1, 16'h8000);
      probe(MESH_ROWS - 1, MESH_COLS - 1);

      // zero rows act as one row, oversized columns clip, largest scale
      apply_setting(16'h0000, 16'hFFFF, 16'hFFFF);
      probe(0, 10);
      probe(0, MESH_COLS - 1);
      send_item(pls_pkg::OP_COMPUTE, MESH_ROWS - 1, MESH_COLS - 1, 16'hFFFF);
      put_sample(7, 7, 16'h1234);

      // single column, zero scale, rows above the maximum
      apply_setting(16'd100, 16'd1, 16'd0);
      probe(20, 0);
      send_item(pls_pkg::OP_COMPUTE, 20, MESH_COLS - 1, 16'h0000);

      // two by two mesh, smallest scale so rounding dominates
      apply_setting(16'd2, 16'd2, 16'd1);
      probe(1, 1);
      probe(0, 0);

      // random settings and traffic
      while (computes_sent + writes_kept < ITEM_TARGET - QUIET_ITEMS) begin
         program_random();
         run_phase($urandom_range(60, 140));
      end

      // closing stretch without idling
      program_random();
      quiet <= 1'b1;
      run_phase(QUIET_ITEMS);
      wait_idle();

      $display("Sent %0d sample writes and %0d Laplacian requests over %0d register settings,",
               writes_sent, computes_sent, settings_used);
      $display("with random idling on both sides; %0d results compared, %0d out of range.",
               results_checked, range_results);
      if (mismatch_count == 0 && results_owed == 0) begin
         $display("periodic_laplacian_stencil_tb passed");
      end else begin
         $display("periodic_laplacian_stencil_tb failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
